### src/tsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_pkg
// shared types and constants of the timestamp stream merge
// ----------------------------------------------------------------------------
package tsm_pkg;

   localparam int NUM_SOURCES_DEF = 16;
   localparam int SOURCE_W        = 4;
   localparam int TIME_W          = 64;
   localparam int PAYLOAD_W       = 64;
   localparam int CSR_W           = 5;
   localparam int HEAD_W          = TIME_W + PAYLOAD_W;

   localparam logic [CSR_W-1:0] ACTIVE_SOURCES_RST = CSR_W'(16);

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_CLOSE = 1'b1
   } tsm_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } tsm_state_type;

   typedef struct packed {
      logic                 valid;
      logic [SOURCE_W-1:0]  source;
      logic [TIME_W-1:0]    event_time;
      logic [PAYLOAD_W-1:0] event_payload;
   } tsm_emit_type;

endpackage

### src/tsm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_req_if
// input channel: push or close commands per source
// ----------------------------------------------------------------------------
interface tsm_req_if import tsm_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic [SOURCE_W-1:0]  source;
   logic [TIME_W-1:0]    event_time;
   logic [PAYLOAD_W-1:0] event_payload;

   modport source_mp (output valid, output opcode, output source, output event_time,
                      output event_payload, input ready);
   modport sink (input valid, input opcode, input source, input event_time,
                 input event_payload, output ready);

endinterface

### src/tsm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_rsp_if
// result channel: merged records in timestamp order
// ----------------------------------------------------------------------------
interface tsm_rsp_if import tsm_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [SOURCE_W-1:0]  out_source;
   logic [TIME_W-1:0]    out_time;
   logic [PAYLOAD_W-1:0] out_payload;

   modport source_mp (output valid, output out_source, output out_time, output out_payload,
                      input ready);
   modport sink (input valid, input out_source, input out_time, input out_payload,
                 output ready);

endinterface

### src/timestamp_stream_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_stream_merge
// k-way merge of timestamp-sorted event streams through one-entry head slots
// ----------------------------------------------------------------------------
// req_chan carries one command per item: push a record into a source's head
// slot, or close the source. rsp_chan carries the merged records, smallest
// timestamp first, ties to the lowest source. csr_wr_en/csr_wr_data set the
// number of sources in use (reset 16), to be written only while the block is
// idle; the block itself does not enforce this. An item is taken in the idle
// state, then the head ram is scanned one slot a cycle through its registered
// read port; the scan stops early at an open source with an empty slot. Each
// head read is compared against the best-so-far registers and, when the scan
// ran to the end, the emit step loads the smallest head into the output register.
// The output register holds a result while the receiver stalls; the next item
// is still taken and scanned, and its own result waits in the emit step until
// the register frees. Reset empties and reopens every slot and clears rsp
// valid; the head ram itself is not cleared.
// ----------------------------------------------------------------------------
module timestamp_stream_merge import tsm_pkg::*; #(
   parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   tsm_req_if.sink          req_chan,
   tsm_rsp_if.source_mp     rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(NUM_SOURCES);
   localparam int CNT_W = $clog2(NUM_SOURCES + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   logic [CSR_W-1:0]     active_sources_ff;
   logic [CMP_W-1:0]     active_ext;
   logic [CMP_W-1:0]     n_capped;
   logic [CNT_W-1:0]     n_in_use;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [HEAD_W-1:0]    ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [HEAD_W-1:0]    ram_rd_data;
   logic                 slot_free;
   tsm_emit_type         emit;

   logic                 rsp_valid_ff;
   logic [SOURCE_W-1:0]  rsp_source_ff;
   logic [TIME_W-1:0]    rsp_time_ff;
   logic [PAYLOAD_W-1:0] rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_sources_ff <= ACTIVE_SOURCES_RST;
      end else if (csr_wr_en) begin
         active_sources_ff <= csr_wr_data;
      end
   end

   // sources in use, capped at the slot count
   assign active_ext = CMP_W'(active_sources_ff);
   assign n_capped   = (active_ext > CMP_W'(NUM_SOURCES)) ? CMP_W'(NUM_SOURCES) : active_ext;
   assign n_in_use   = n_capped[CNT_W-1:0];

   tsm_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (NUM_SOURCES)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tsm_ctrl #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .n_in_use    (n_in_use),
      .req_chan    (req_chan),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .slot_free   (slot_free),
      .emit        (emit)
   );

   // output register
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_source_ff  <= emit.source;
         rsp_time_ff    <= emit.event_time;
         rsp_payload_ff <= emit.event_payload;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_source  = rsp_source_ff;
   assign rsp_chan.out_time    = rsp_time_ff;
   assign rsp_chan.out_payload = rsp_payload_ff;

endmodule

### src/tsm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_ctrl
// head slot flags, command apply and minimum scan over the head ram
// ----------------------------------------------------------------------------
module tsm_ctrl import tsm_pkg::*; #(
   parameter int NUM_SOURCES = NUM_SOURCES_DEF,
   localparam int IDX_W = $clog2(NUM_SOURCES),
   localparam int CNT_W = $clog2(NUM_SOURCES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CNT_W-1:0]   n_in_use,
   tsm_req_if.sink            req_chan,
   output logic               ram_wr_en,
   output logic [IDX_W-1:0]   ram_wr_addr,
   output logic [HEAD_W-1:0]  ram_wr_data,
   output logic               ram_rd_en,
   output logic [IDX_W-1:0]   ram_rd_addr,
   input  logic [HEAD_W-1:0]  ram_rd_data,
   input  logic               slot_free,
   output tsm_emit_type       emit
);

   localparam int CMP_W = (CNT_W > SOURCE_W + 1) ? CNT_W : SOURCE_W + 1;

   tsm_state_type          state_ff, state_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   pend_ff;
   logic [IDX_W-1:0]       pend_idx_ff;
   logic                   found_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [TIME_W-1:0]      best_time_ff;
   logic [PAYLOAD_W-1:0]   best_payload_ff;
   logic [NUM_SOURCES-1:0] full_ff;
   logic [NUM_SOURCES-1:0] closed_ff;

   logic [CMP_W-1:0]     src_ext;
   logic [IDX_W-1:0]     src_idx;
   logic                 src_use;
   logic                 accept;
   logic                 do_push;
   logic                 do_close;
   logic [IDX_W-1:0]     scan_idx;
   logic                 scan_live;
   logic                 blocked;
   logic                 emit_go;
   logic [TIME_W-1:0]    rd_time;
   logic [PAYLOAD_W-1:0] rd_payload;
   logic                 take_new;

   assign src_ext  = CMP_W'(req_chan.source);
   assign src_idx  = src_ext[IDX_W-1:0];
   assign src_use  = src_ext < CMP_W'(n_in_use);
   assign accept   = req_chan.valid && req_chan.ready;
   assign do_push  = accept && src_use && (req_chan.opcode == OP_PUSH)
                     && !full_ff[src_idx] && !closed_ff[src_idx];
   assign do_close = accept && src_use && (req_chan.opcode == OP_CLOSE);

   assign scan_idx  = idx_ff[IDX_W-1:0];
   assign scan_live = idx_ff < n_in_use;
   assign blocked   = scan_live && !full_ff[scan_idx] && !closed_ff[scan_idx];

   assign emit_go    = (state_ff == ST_EMIT) && found_ff && slot_free;
   assign rd_time    = ram_rd_data[HEAD_W-1:PAYLOAD_W];
   assign rd_payload = ram_rd_data[PAYLOAD_W-1:0];
   assign take_new   = pend_ff && (!found_ff || (rd_time < best_time_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!scan_live) begin
               state_in = ST_EMIT;
            end else if (blocked) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!found_ff || slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      ram_rd_en      = 1'b0;
      idx_in         = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            idx_in         = '0;
         end
         ST_SCAN: begin
            if (scan_live) begin
               ram_rd_en = full_ff[scan_idx];
               idx_in    = idx_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            idx_in = idx_ff;
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   assign ram_rd_addr = scan_idx;
   assign ram_wr_en   = do_push;
   assign ram_wr_addr = src_idx;
   assign ram_wr_data = {req_chan.event_time, req_chan.event_payload};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         full_ff   <= '0;
         closed_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= ram_rd_en;
         if (accept) begin
            found_ff <= 1'b0;
         end else if (take_new) begin
            found_ff <= 1'b1;
         end
         if (do_push) begin
            full_ff[src_idx] <= 1'b1;
         end
         if (emit_go) begin
            full_ff[best_idx_ff] <= 1'b0;
         end
         if (do_close) begin
            closed_ff[src_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         pend_idx_ff <= scan_idx;
      end
      if (take_new) begin
         best_idx_ff     <= pend_idx_ff;
         best_time_ff    <= rd_time;
         best_payload_ff <= rd_payload;
      end
   end

   assign emit.valid         = emit_go;
   assign emit.source        = SOURCE_W'(best_idx_ff);
   assign emit.event_time    = best_time_ff;
   assign emit.event_payload = best_payload_ff;

endmodule

### src/tsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_checker
// port level checks of the timestamp stream merge, bound to the top level
// ----------------------------------------------------------------------------
module tsm_checker import tsm_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [SOURCE_W-1:0]  rsp_source,
   input logic [TIME_W-1:0]    rsp_time,
   input logic [PAYLOAD_W-1:0] rsp_payload
);

   // one item at a time: no new item right after one is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
   else $error("req ready right after an accepted item");

   // a result never shows up in the cycle after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
   else $error("result too soon after an accepted item");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
   else $error("rsp valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_source) && $stable(rsp_time) && $stable(rsp_payload)))
   else $error("stalled result changed");

endmodule

bind timestamp_stream_merge tsm_checker u_tsm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_source  (rsp_chan.out_source),
   .rsp_time    (rsp_chan.out_time),
   .rsp_payload (rsp_chan.out_payload)
);

### test/timestamp_stream_merge_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_stream_merge_tb
// self-checking bench for the timestamp stream merge
// ----------------------------------------------------------------------------
// A queue of push and close commands feeds the request channel through a
// clocked driver. Each accepted item steps a shadow merger kept in the bench;
// the record it emits, if any, goes to a queue of expected merged records that
// the clocked monitor checks field by field against the result channel. A
// second shadow merger, stepped while the stimulus is built, steers pushes
// towards empty head slots so that most items form well-behaved streams.
// Phases at different source counts (reset value, one, zero, all, capped, and
// random) are separated by idle points where the source count is rewritten.
// The last phase closes every source and drains the held records.
// ----------------------------------------------------------------------------
module timestamp_stream_merge_tb;
   import tsm_pkg::*;

   localparam int LONG_HOLD   = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 40;

   typedef struct packed {
      tsm_op_type           op;
      logic [SOURCE_W-1:0]  source;
      logic [TIME_W-1:0]    stamp;
      logic [PAYLOAD_W-1:0] payload;
   } merge_cmd_type;

   typedef struct packed {
      logic [SOURCE_W-1:0]  out_source;
      logic [TIME_W-1:0]    out_time;
      logic [PAYLOAD_W-1:0] out_payload;
   } merge_rec_type;

   typedef struct packed {
      logic [CSR_W-1:0]                            active;
      logic [NUM_SOURCES_DEF-1:0]                  full;
      logic [NUM_SOURCES_DEF-1:0]                  closed;
      logic [NUM_SOURCES_DEF-1:0][TIME_W-1:0]      head_stamp;
      logic [NUM_SOURCES_DEF-1:0][PAYLOAD_W-1:0]   head_payload;
   } merge_state_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   tsm_req_if req_chan ();
   tsm_rsp_if rsp_chan ();

   timestamp_stream_merge dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   merge_cmd_type   cmd_q[$];
   merge_rec_type   merged_q[$];
   merge_state_type merger;
   merge_state_type plan;
   merge_cmd_type   cur_cmd;
   logic [TIME_W-1:0] next_stamp [NUM_SOURCES_DEF];

   int mismatches   = 0;
   int records_seen = 0;
   int send_gap     = 0;
   int send_calm    = 0;
   int hold_left    = 0;
   int sink_calm    = 0;
   int idle_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int in_use(logic [CSR_W-1:0] a);
      return (a > NUM_SOURCES_DEF) ? NUM_SOURCES_DEF : int'(a);
   endfunction

   // mostly short gaps, a few long ones, and calm stretches with none
   function automatic int idle_span(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic merge_state_type merge_reset_state();
      merge_state_type st;
      st        = '0;
      st.active = ACTIVE_SOURCES_RST;
      return st;
   endfunction

   // apply one command, then emit the smallest head once no open source is empty
   function automatic void merge_step(inout merge_state_type st, input merge_cmd_type cmd,
                                      output merge_rec_type rec, output bit emitted);
      int n;
      int i;
      int best;
      bit found;
      bit blocked;
      n       = in_use(st.active);
      rec     = '0;
      emitted = 1'b0;
      found   = 1'b0;
      blocked = 1'b0;
      best    = 0;
      if (int'(cmd.source) < n) begin
         if (cmd.op == OP_PUSH) begin
            if (!st.full[cmd.source] && !st.closed[cmd.source]) begin
               st.full[cmd.source]         = 1'b1;
               st.head_stamp[cmd.source]   = cmd.stamp;
               st.head_payload[cmd.source] = cmd.payload;
            end
         end else begin
            st.closed[cmd.source] = 1'b1;
         end
      end
      for (i = 0; i < n; i++) begin
         if (!blocked) begin
            if (!st.full[i]) begin
               if (!st.closed[i]) blocked = 1'b1;
            end else if (!found || st.head_stamp[i] < st.head_stamp[best]) begin
               found = 1'b1;
               best  = i;
            end
         end
      end
      if (found && !blocked) begin
         st.full[best]   = 1'b0;
         rec.out_source  = SOURCE_W'(best);
         rec.out_time    = st.head_stamp[best];
         rec.out_payload = st.head_payload[best];
         emitted         = 1'b1;
      end
   endfunction

   task automatic queue_cmd(input tsm_op_type op, input int src,
                            input logic [TIME_W-1:0] t, input logic [PAYLOAD_W-1:0] p);
      merge_cmd_type cmd;
      merge_rec_type rec;
      bit            hit;
      cmd.op      = op;
      cmd.source  = SOURCE_W'(src);
      cmd.stamp   = t;
      cmd.payload = p;
      cmd_q.push_back(cmd);
      merge_step(plan, cmd, rec, hit);
   endtask

   task automatic start_stamps(input logic [TIME_W-1:0] base);
      int s;
      for (s = 0; s < NUM_SOURCES_DEF; s++) next_stamp[s] = base;
   endtask

   // streams with random content, plus dropped pushes and ignored noise
   task automatic random_phase(input int count);
      int k;
      int s;
      int n;
      int r;
      int empties[$];
      for (k = 0; k < count; k++) begin
         n = in_use(plan.active);
         r = $urandom_range(0, 99);
         empties.delete();
         for (s = 0; s < n; s++)
            if (!plan.full[s] && !plan.closed[s]) empties.push_back(s);
         if (n == 0) begin
            queue_cmd($urandom_range(0, 1) ? OP_CLOSE : OP_PUSH, $urandom_range(0, 15),
                      rand64(), rand64());
         end else if (r < 88) begin
            if (r < 80 && empties.size() > 0)
               s = empties[$urandom_range(0, empties.size() - 1)];
            else
               s = $urandom_range(0, n - 1);
            if ($urandom_range(0, 9) == 0)
               next_stamp[s] = next_stamp[s] + TIME_W'($urandom);
            else
               next_stamp[s] = next_stamp[s] + TIME_W'($urandom_range(0, 6));
            queue_cmd(OP_PUSH, s, next_stamp[s], rand64());
         end else if (r < 93) begin
            queue_cmd(OP_PUSH, $urandom_range(0, 15), rand64(), rand64());
         end else if (r < 96) begin
            queue_cmd(OP_PUSH, $urandom_range(0, n - 1),
                      $urandom_range(0, 1) ? '1 : '0, $urandom_range(0, 1) ? '1 : '0);
         end else if (n < NUM_SOURCES_DEF) begin
            queue_cmd($urandom_range(0, 1) ? OP_CLOSE : OP_PUSH,
                      $urandom_range(n, NUM_SOURCES_DEF - 1), rand64(), rand64());
         end else begin
            queue_cmd(OP_PUSH, $urandom_range(0, 15), rand64(), rand64());
         end
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (cmd_q.size() != 0 || req_chan.valid || merged_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_active(input logic [CSR_W-1:0] value);
      wait_idle();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      merger.active = value;
      plan.active   = value;
      @(negedge clock);
   endtask

   // driver: predicts on every accepted item, then loads the next one
   always @(posedge clock) begin
      merge_rec_type rec;
      bit            hit;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            merge_step(merger, cur_cmd, rec, hit);
            if (hit) merged_q.push_back(rec);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
               cur_cmd = cmd_q.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.opcode        <= cur_cmd.op;
               req_chan.source        <= cur_cmd.source;
               req_chan.event_time    <= cur_cmd.stamp;
               req_chan.event_payload <= cur_cmd.payload;
               send_gap = idle_span(send_calm);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks merged records and stalls the result channel
   always @(posedge clock) begin
      merge_rec_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (merged_q.size() == 0) begin
               $error("unexpected record: source %0d time %h payload %h",
                      rsp_chan.out_source, rsp_chan.out_time, rsp_chan.out_payload);
               mismatches++;
            end else begin
               want = merged_q.pop_front();
               if (rsp_chan.out_source !== want.out_source) begin
                  $error("out_source: expected %0d, got %0d", want.out_source,
                         rsp_chan.out_source);
                  mismatches++;
               end
               if (rsp_chan.out_time !== want.out_time) begin
                  $error("out_time: expected %h, got %h", want.out_time, rsp_chan.out_time);
                  mismatches++;
               end
               if (rsp_chan.out_payload !== want.out_payload) begin
                  $error("out_payload: expected %h, got %h", want.out_payload,
                         rsp_chan.out_payload);
                  mismatches++;
               end
            end
            records_seen++;
            // long back-pressure so the block fills and stalls its input
            if (records_seen == 150 || records_seen == 800) hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) hold_left = idle_span(sink_calm);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int k;
      int j;
      int tmp;
      int order[NUM_SOURCES_DEF];
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      req_chan.valid         = 1'b0;
      req_chan.opcode        = OP_PUSH;
      req_chan.source        = '0;
      req_chan.event_time    = '0;
      req_chan.event_payload = '0;
      rsp_chan.ready         = 1'b0;
      merger                 = merge_reset_state();
      plan                   = merge_reset_state();
      start_stamps('0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset source count, ties, extremes, drops, closes
      queue_cmd(OP_PUSH, 15, 64'd100, '1);
      queue_cmd(OP_CLOSE, 14, rand64(), rand64());
      queue_cmd(OP_PUSH, 0, '0, '0);
      queue_cmd(OP_PUSH, 1, 64'd5, rand64());
      queue_cmd(OP_PUSH, 2, 64'd5, rand64());
      queue_cmd(OP_PUSH, 3, '1, '1);
      for (k = 4; k < 14; k++) queue_cmd(OP_PUSH, k, TIME_W'(10 + k), rand64());
      queue_cmd(OP_PUSH, 1, 64'd1, rand64());
      queue_cmd(OP_PUSH, 14, 64'd2, rand64());
      queue_cmd(OP_CLOSE, 14, rand64(), rand64());
      queue_cmd(OP_PUSH, 0, 64'd5, rand64());
      queue_cmd(OP_CLOSE, 15, rand64(), rand64());
      queue_cmd(OP_PUSH, 0, 64'd200, rand64());
      queue_cmd(OP_PUSH, 1, 64'd300, rand64());
      queue_cmd(OP_PUSH, 2, 64'd400, rand64());

      set_active(5'd1);
      start_stamps(64'd1000);
      random_phase(50);

      set_active(5'd0);
      random_phase(12);

      set_active(5'd16);
      start_stamps(rand64());
      random_phase(500);

      set_active(5'd31);
      start_stamps('1 - 64'd5000);
      random_phase(200);

      for (k = 0; k < 3; k++) begin
         set_active(CSR_W'($urandom_range(2, 15)));
         start_stamps(rand64());
         random_phase(120);
      end

      set_active(CSR_W'($urandom_range(17, 30)));
      start_stamps(rand64());
      random_phase(80);

      // close every source in random order, then drain the held records
      set_active(5'd16);
      start_stamps(rand64());
      for (k = 0; k < NUM_SOURCES_DEF; k++) order[k] = k;
      for (k = NUM_SOURCES_DEF - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      for (k = 0; k < NUM_SOURCES_DEF; k++) begin
         random_phase($urandom_range(1, 4));
         queue_cmd(OP_CLOSE, order[k], rand64(), rand64());
      end
      repeat (20) queue_cmd(OP_PUSH, $urandom_range(0, 15), rand64(), rand64());

      wait_idle();
      repeat (60) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
